// ===== src/lmg_pkg.sv =====
`default_nettype none

package lmg_pkg;

	// mesh limits
	localparam int MAX_POINTS = 4096;
	localparam int MAX_SLICES = 15;
	localparam int MIN_SLICES = 3;

	// quarter-wave sine table
	localparam int SINE_DEPTH = 256;
	localparam int TAB_W      = $clog2(SINE_DEPTH);
	localparam int TAB_IW     = TAB_W + 1;
	localparam int WAVE_W     = TAB_W + 2;
	localparam int PHASE_W    = 16;

	// field and register widths
	localparam int DATA_W     = 16;
	localparam int IDX_W      = 16;
	localparam int NP_W       = 13;
	localparam int SL_W       = 4;
	localparam int ROW_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int PROD_W     = 33;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RISING      = 2'd3;

	localparam logic [NP_W-1:0]    POINT_COUNT_RST = 13'd2;
	localparam logic [SL_W-1:0]    SLICE_COUNT_RST = 4'd8;
	localparam logic [PHASE_W-1:0] ANGLE_STEP_RST  = 16'd8192;

	// record kinds
	localparam logic KIND_VERTEX   = 1'b0;
	localparam logic KIND_TRIANGLE = 1'b1;

	// what the datapath puts into the output register
	typedef enum logic [2:0] {
		REC_NONE,
		REC_VERT,
		REC_QUAD,
		REC_BOT,
		REC_TOP,
		REC_CEN0,
		REC_CEN1
	} rec_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_V_LOOK,
		S_V_MUL,
		S_V_EMIT,
		S_QUAD,
		S_BOT,
		S_TOP,
		S_CEN0,
		S_CEN1
	} lmg_state_t;

	typedef struct packed {
		logic     load;
		logic     look;
		logic     mul;
		rec_sel_t emit;
		logic     j_step;
		logic     j_clear;
	} lmg_cmd_t;

	typedef struct packed {
		logic out_free;
		logic j_last;
		logic pair;
		logic row_first;
		logic row_last;
	} lmg_status_t;

	// sine table, built at elaboration: Q30 Taylor series to ninth order
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [DATA_W-1:0] sine_tab_t [0:SINE_DEPTH];

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t   tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] v;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			x  = (HALF_PI_Q30 * 64'(k)) / SINE_DEPTH;
			x2 = (x * x) >> 30;
			t  = Q30_ONE - x2 / 72;
			t  = Q30_ONE - ((x2 * t) >> 30) / 42;
			t  = Q30_ONE - ((x2 * t) >> 30) / 20;
			t  = Q30_ONE - ((x2 * t) >> 30) / 6;
			t  = (x * t) >> 30;
			v  = (t * 64'd32768 + (64'd1 << 29)) >> 30;
			if (v > 64'd32768) begin
				v = 64'd32768;
			end
			tab[k] = v[DATA_W-1:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

	// full-wave sine from the quarter table, Q15 with +-32768 reachable
	function automatic logic signed [DATA_W:0] sine_at(input logic [WAVE_W-1:0] p);
		logic [1:0]        q;
		logic [TAB_W-1:0]  r;
		logic [TAB_IW-1:0] idx;
		logic [DATA_W:0]   v;
		q   = p[WAVE_W-1 -: 2];
		r   = p[TAB_W-1:0];
		idx = q[0] ? (TAB_IW'(SINE_DEPTH) - {1'b0, r}) : {1'b0, r};
		v   = {1'b0, SINE_TAB[idx]};
		return q[1] ? -v : v;
	endfunction

endpackage

`default_nettype wire

// ===== src/lmg_ctrl.sv =====
`default_nettype none

module lmg_ctrl
	import lmg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        profile_valid,
	output logic             profile_stall,
	input  wire lmg_status_t status,
	output lmg_cmd_t         cmd
);

	lmg_state_t state_q;
	lmg_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (profile_valid) state_d = S_V_LOOK;
			end
			S_V_LOOK: state_d = S_V_MUL;
			S_V_MUL:  state_d = S_V_EMIT;
			S_V_EMIT: begin
				if (status.out_free) begin
					if (!status.j_last)        state_d = S_V_LOOK;
					else if (status.row_first) state_d = S_BOT;
					else                       state_d = S_QUAD;
				end
			end
			S_QUAD: begin
				if (status.out_free && status.pair && status.j_last) begin
					state_d = status.row_last ? S_TOP : S_IDLE;
				end
			end
			S_BOT: begin
				if (status.out_free && status.j_last) begin
					state_d = status.row_last ? S_TOP : S_IDLE;
				end
			end
			S_TOP: begin
				if (status.out_free && status.j_last) state_d = S_CEN0;
			end
			S_CEN0: begin
				if (status.out_free) state_d = S_CEN1;
			end
			S_CEN1: begin
				if (status.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd           = '0;
		cmd.emit      = REC_NONE;
		profile_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE:   cmd.load = profile_valid;
			S_V_LOOK: cmd.look = 1'b1;
			S_V_MUL:  cmd.mul  = 1'b1;
			S_V_EMIT: begin
				if (status.out_free) begin
					cmd.emit    = REC_VERT;
					cmd.j_clear = status.j_last;
					cmd.j_step  = !status.j_last;
				end
			end
			S_QUAD: begin
				if (status.out_free) begin
					cmd.emit    = REC_QUAD;
					cmd.j_clear = status.pair && status.j_last;
					cmd.j_step  = status.pair && !status.j_last;
				end
			end
			S_BOT, S_TOP: begin
				if (status.out_free) begin
					cmd.emit    = (state_q == S_BOT) ? REC_BOT : REC_TOP;
					cmd.j_clear = status.j_last;
					cmd.j_step  = !status.j_last;
				end
			end
			S_CEN0: begin
				if (status.out_free) cmd.emit = REC_CEN0;
			end
			S_CEN1: begin
				if (status.out_free) cmd.emit = REC_CEN1;
			end
			default: begin
				cmd.emit = REC_NONE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_cen1_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CEN1 && status.out_free) |=> (state_q == S_IDLE))
		else $error("second centre vertex did not end the point");

	a_quad_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QUAD && status.out_free && status.pair && status.j_last &&
		 !status.row_last) |=> (state_q == S_IDLE))
		else $error("last quad of a middle row did not end the point");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_q != S_CEN1 && state_q != S_QUAD &&
		 state_q != S_BOT) |=> (state_q != S_IDLE))
		else $error("point ended outside a closing record");
`endif

endmodule

`default_nettype wire

// ===== src/lmg_dp.sv =====
`default_nettype none

module lmg_dp
	import lmg_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_write,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data,
	input  wire logic signed [DATA_W-1:0] radius,
	input  wire logic signed [DATA_W-1:0] height,
	input  wire logic                     record_stall,
	input  wire lmg_cmd_t                 cmd,
	output lmg_status_t                   status,
	output logic                          record_valid,
	output logic                          record_kind,
	output logic [IDX_W-1:0]              vertex_index,
	output logic signed [DATA_W-1:0]      vertex_x,
	output logic signed [DATA_W-1:0]      vertex_y,
	output logic signed [DATA_W-1:0]      vertex_z,
	output logic [IDX_W-1:0]              corner_a,
	output logic [IDX_W-1:0]              corner_b,
	output logic [IDX_W-1:0]              corner_c,
	output logic                          last_of_run
);

	// round to nearest (half up), then clamp to 16 bits
	function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W:0]   v;
		logic signed [PROD_W-15:0] q;
		logic signed [DATA_W-1:0] r;
		v = {p[PROD_W-1], p} + (PROD_W+1)'(16384);
		q = v[PROD_W:15];
		if (q > (PROD_W-14)'(32767)) begin
			r = 16'sh7fff;
		end else if (q < -(PROD_W-14)'(32768)) begin
			r = 16'sh8000;
		end else begin
			r = q[DATA_W-1:0];
		end
		return r;
	endfunction

	// configuration
	logic [NP_W-1:0]    point_count_q;
	logic [SL_W-1:0]    slice_count_q;
	logic [PHASE_W-1:0] angle_step_q;
	logic               rising_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= POINT_COUNT_RST;
			slice_count_q <= SLICE_COUNT_RST;
			angle_step_q  <= ANGLE_STEP_RST;
			rising_q      <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_POINT_COUNT: point_count_q <= cfg_data[NP_W-1:0];
				REG_SLICE_COUNT: slice_count_q <= cfg_data[SL_W-1:0];
				REG_ANGLE_STEP:  angle_step_q  <= cfg_data[PHASE_W-1:0];
				REG_RISING:      rising_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective counts and row of the arriving point
	logic [NP_W-1:0]  np_eff;
	logic [NP_W-1:0]  np_m1;
	logic [SL_W-1:0]  s_eff;
	logic [ROW_W-1:0] row;
	logic             row_is_last;
	logic [ROW_W-1:0] rows_seen_q;

	always_comb begin
		if (point_count_q == '0) begin
			np_eff = NP_W'(1);
		end else if (point_count_q > NP_W'(MAX_POINTS)) begin
			np_eff = NP_W'(MAX_POINTS);
		end else begin
			np_eff = point_count_q;
		end
		if (slice_count_q < SL_W'(MIN_SLICES)) begin
			s_eff = SL_W'(MIN_SLICES);
		end else if (slice_count_q > SL_W'(MAX_SLICES)) begin
			s_eff = SL_W'(MAX_SLICES);
		end else begin
			s_eff = slice_count_q;
		end
		np_m1       = np_eff - NP_W'(1);
		row         = ({1'b0, rows_seen_q} > np_m1) ? np_m1[ROW_W-1:0] : rows_seen_q;
		row_is_last = (row == np_m1[ROW_W-1:0]);
	end

	// per-point registers
	logic signed [DATA_W-1:0] radius_q;
	logic signed [DATA_W-1:0] height_q;
	logic signed [DATA_W-1:0] first_height_q;
	logic [IDX_W-1:0]         base_q;
	logic [IDX_W-1:0]         top_q;
	logic [SL_W-1:0]          s_q;
	logic                     row_first_q;
	logic                     row_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_seen_q    <= '0;
			first_height_q <= '0;
			s_q            <= SL_W'(MIN_SLICES);
			row_first_q    <= 1'b0;
			row_last_q     <= 1'b0;
		end else if (cmd.load) begin
			rows_seen_q <= row_is_last ? '0 : row + ROW_W'(1);
			if (row == '0) begin
				first_height_q <= height;
			end
			s_q         <= s_eff;
			row_first_q <= (row == '0);
			row_last_q  <= row_is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			radius_q <= radius;
			height_q <= height;
			base_q   <= IDX_W'(row) * IDX_W'(s_eff);
			top_q    <= IDX_W'(np_eff) * IDX_W'(s_eff);
		end
	end

	// slice counter, phase accumulator, triangle pair toggle
	logic [SL_W-1:0]    j_q;
	logic [PHASE_W-1:0] phase_q;
	logic               pair_q;
	logic               j_last;

	assign j_last = (j_q == s_q - SL_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q     <= '0;
			phase_q <= '0;
			pair_q  <= 1'b0;
		end else begin
			if (cmd.load || cmd.j_clear) begin
				j_q     <= '0;
				phase_q <= '0;
			end else if (cmd.j_step) begin
				j_q     <= j_q + SL_W'(1);
				phase_q <= phase_q + angle_step_q;
			end
			if (cmd.load || cmd.j_clear) begin
				pair_q <= 1'b0;
			end else if (cmd.emit == REC_QUAD) begin
				pair_q <= !pair_q;
			end
		end
	end

	// vertex path: table lookup, then multiply
	logic [WAVE_W-1:0]        p_sin;
	logic [WAVE_W-1:0]        p_cos;
	logic signed [DATA_W:0]   sin_s1;
	logic signed [DATA_W:0]   cos_s1;
	logic signed [PROD_W-1:0] xprod_s2;
	logic signed [PROD_W-1:0] yprod_s2;

	assign p_sin = phase_q[PHASE_W-1 -: WAVE_W];
	assign p_cos = {p_sin[WAVE_W-1 -: 2] + 2'd1, p_sin[TAB_W-1:0]};

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			sin_s1 <= sine_at(p_sin);
			cos_s1 <= sine_at(p_cos);
		end
		if (cmd.mul) begin
			xprod_s2 <= PROD_W'(radius_q) * PROD_W'(cos_s1);
			yprod_s2 <= PROD_W'(radius_q) * PROD_W'(sin_s1);
		end
	end

	// vertex numbers around the current slice
	logic [SL_W-1:0]  jn;
	logic [IDX_W-1:0] j_ext;
	logic [IDX_W-1:0] jn_ext;
	logic [IDX_W-1:0] bj;
	logic [IDX_W-1:0] bjn;
	logic [IDX_W-1:0] aj;
	logic [IDX_W-1:0] dj;
	logic [IDX_W-1:0] top1;

	always_comb begin
		jn     = j_last ? '0 : j_q + SL_W'(1);
		j_ext  = IDX_W'(j_q);
		jn_ext = IDX_W'(jn);
		bj     = base_q + j_ext;
		bjn    = base_q + jn_ext;
		aj     = bj - IDX_W'(s_q);
		dj     = bjn - IDX_W'(s_q);
		top1   = top_q + IDX_W'(1);
	end

	// output register
	logic                     out_valid_q;
	logic                     kind_d;
	logic [IDX_W-1:0]         idx_d;
	logic signed [DATA_W-1:0] x_d;
	logic signed [DATA_W-1:0] y_d;
	logic signed [DATA_W-1:0] z_d;
	logic [IDX_W-1:0]         ca_d;
	logic [IDX_W-1:0]         cb_d;
	logic [IDX_W-1:0]         cc_d;
	logic                     last_d;
	logic                     out_free;

	assign out_free = !out_valid_q || !record_stall;

	always_comb begin
		kind_d = KIND_VERTEX;
		idx_d  = '0;
		x_d    = '0;
		y_d    = '0;
		z_d    = '0;
		ca_d   = '0;
		cb_d   = '0;
		cc_d   = '0;
		last_d = 1'b0;
		case (cmd.emit)
			REC_VERT: begin
				idx_d = bj;
				x_d   = round_sat(xprod_s2);
				y_d   = round_sat(yprod_s2);
				z_d   = height_q;
			end
			REC_QUAD: begin
				kind_d = KIND_TRIANGLE;
				if (!pair_q) begin
					ca_d = rising_q ? bjn : aj;
					cb_d = bj;
					cc_d = rising_q ? aj : bjn;
				end else begin
					ca_d = rising_q ? dj : aj;
					cb_d = bjn;
					cc_d = rising_q ? aj : dj;
				end
				last_d = pair_q && j_last && !row_last_q;
			end
			REC_BOT: begin
				kind_d = KIND_TRIANGLE;
				ca_d   = rising_q ? jn_ext : top_q;
				cb_d   = j_ext;
				cc_d   = rising_q ? top_q : jn_ext;
				last_d = j_last && !row_last_q;
			end
			REC_TOP: begin
				kind_d = KIND_TRIANGLE;
				ca_d   = rising_q ? top1 : bjn;
				cb_d   = bj;
				cc_d   = rising_q ? bjn : top1;
			end
			REC_CEN0: begin
				idx_d = top_q;
				z_d   = first_height_q;
			end
			REC_CEN1: begin
				idx_d  = top1;
				z_d    = height_q;
				last_d = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != REC_NONE) begin
			out_valid_q <= 1'b1;
		end else if (!record_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != REC_NONE) begin
			record_kind  <= kind_d;
			vertex_index <= idx_d;
			vertex_x     <= x_d;
			vertex_y     <= y_d;
			vertex_z     <= z_d;
			corner_a     <= ca_d;
			corner_b     <= cb_d;
			corner_c     <= cc_d;
			last_of_run  <= last_d;
		end
	end

	assign record_valid = out_valid_q;

	assign status.out_free  = out_free;
	assign status.j_last    = j_last;
	assign status.pair      = pair_q;
	assign status.row_first = row_first_q;
	assign status.row_last  = row_last_q;

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit != REC_NONE) |-> out_free)
		else $error("record written over an untaken beat");

	a_phase_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(j_q == '0) |-> (phase_q == '0))
		else $error("phase out of step with slice counter");

	a_slice_range: assert property (@(posedge clk) disable iff (!arst_n)
		j_q < s_q)
		else $error("slice counter ran past slice count");
`endif

endmodule

`default_nettype wire

// ===== src/lathe_mesh_generator_unit.sv =====
// Lathe mesh generator: turns a stream of profile points into a
// surface-of-revolution mesh, one record per output beat.
// Profile channel: profile_valid/profile_stall carry radius and height.
// A point is taken only while the block is idle; it then emits its ring of
// S vertices, the 2*S quad triangles joining it to the previous ring (rows
// after the first), the bottom fan (first row), and on the last row the top
// fan and the two centre vertices. last_of_run marks the final beat of a point.
// Record channel: record_valid/record_stall; the output register lets the
// next point be taken while the last record of the previous one waits.
// Per point: an accept step, then for each ring vertex a sine table lookup,
// a multiply on one pair of multipliers and a round and saturate step, then
// the triangle and centre records, each written once the output register is free.
// The first vertex passes the lookup and multiply states after accept and is
// written to the output register from the emit state. Record stalls hold the
// current beat and stop the sequence at its next record. Reset (arst_n low)
// restores the register defaults (2 points, 8 slices, 1/8 turn step, rising
// winding) and starts a new mesh at row 0. The user writes the registers over
// cfg_write/cfg_index/cfg_data only while idle; the block does not enforce it.
`default_nettype none

module lathe_mesh_generator_unit
	import lmg_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// configuration
	input  wire logic                     cfg_write,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data,
	// profile points
	input  wire logic                     profile_valid,
	output logic                          profile_stall,
	input  wire logic signed [DATA_W-1:0] radius,
	input  wire logic signed [DATA_W-1:0] height,
	// mesh records
	output logic                          record_valid,
	input  wire logic                     record_stall,
	output logic                          record_kind,
	output logic [IDX_W-1:0]              vertex_index,
	output logic signed [DATA_W-1:0]      vertex_x,
	output logic signed [DATA_W-1:0]      vertex_y,
	output logic signed [DATA_W-1:0]      vertex_z,
	output logic [IDX_W-1:0]              corner_a,
	output logic [IDX_W-1:0]              corner_b,
	output logic [IDX_W-1:0]              corner_c,
	output logic                          last_of_run
);

	lmg_cmd_t    cmd;
	lmg_status_t status;

	// sequencer: walks ring, quads, fans and centres
	lmg_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.profile_valid (profile_valid),
		.profile_stall (profile_stall),
		.status        (status),
		.cmd           (cmd)
	);

	// registers, trig path, index math and output register
	lmg_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.radius       (radius),
		.height       (height),
		.record_stall (record_stall),
		.cmd          (cmd),
		.status       (status),
		.record_valid (record_valid),
		.record_kind  (record_kind),
		.vertex_index (vertex_index),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_z     (vertex_z),
		.corner_a     (corner_a),
		.corner_b     (corner_b),
		.corner_c     (corner_c),
		.last_of_run  (last_of_run)
	);

endmodule

`default_nettype wire
